### rtl/bbbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bbbc_pkg;

	localparam int NSec    = 4;
	localparam int SecW    = 2;
	localparam int SampleW = 12;
	localparam int OutW    = 18;
	localparam int WordW   = 40;
	localparam int FracW   = 24;
	localparam int CoefW   = 27;
	localparam int HalfW   = 20;
	localparam int OperW   = HalfW + 1;
	localparam int ProdW   = CoefW + OperW;
	localparam int FullW   = ProdW + HalfW;
	localparam int AccW    = 44;
	localparam int OutShift = FracW - 4;

	typedef logic signed [WordW-1:0] word_t;
	typedef logic signed [CoefW-1:0] coef_t;
	typedef logic signed [OperW-1:0] oper_t;
	typedef logic signed [ProdW-1:0] prod_t;
	typedef logic signed [FullW-1:0] full_t;
	typedef logic signed [AccW-1:0]  acc_t;
	typedef logic signed [OutW-1:0]  out_t;

	typedef enum logic [2:0] {
		CoefA1,
		CoefA2,
		CoefB0,
		CoefB1,
		CoefB2
	} coef_sel_t;

	localparam word_t WordMax = {1'b0, {(WordW-1){1'b1}}};
	localparam word_t WordMin = {1'b1, {(WordW-1){1'b0}}};
	localparam out_t  OutMax  = {1'b0, {(OutW-1){1'b1}}};
	localparam out_t  OutMin  = {1'b1, {(OutW-1){1'b0}}};

	// Q3.24 coefficients, one row per section
	function automatic coef_t coef_lookup(input logic [SecW-1:0] sec, input coef_sel_t sel);
		coef_t c;
		c = '0;
		case (sec)
			2'd0: begin
				case (sel)
					CoefA1:  c = 27'sd11858519;
					CoefA2:  c = 27'sd2620774;
					CoefB0:  c = 27'sd4708512;
					CoefB1:  c = 27'sd9417023;
					CoefB2:  c = 27'sd4708512;
					default: c = '0;
				endcase
			end
			2'd1: begin
				case (sel)
					CoefA1:  c = 27'sd15943090;
					CoefA2:  c = 27'sd9071967;
					CoefB0:  c = 27'sd16777216;
					CoefB1:  c = 27'sd33554432;
					CoefB2:  c = 27'sd16777216;
					default: c = '0;
				endcase
			end
			2'd2: begin
				case (sel)
					CoefA1:  c = -27'sd32776034;
					CoefA2:  c = 27'sd16009392;
					CoefB0:  c = 27'sd16777216;
					CoefB1:  c = -27'sd33554432;
					CoefB2:  c = 27'sd16777216;
					default: c = '0;
				endcase
			end
			2'd3: begin
				case (sel)
					CoefA1:  c = -27'sd33227034;
					CoefA2:  c = 27'sd16460352;
					CoefB0:  c = 27'sd16777216;
					CoefB1:  c = -27'sd33554432;
					CoefB2:  c = 27'sd16777216;
					default: c = '0;
				endcase
			end
			default: c = '0;
		endcase
		return c;
	endfunction

	// clamp to the signed 40-bit word range
	function automatic word_t sat_word(input acc_t v);
		word_t r;
		if (v > acc_t'(WordMax)) begin
			r = WordMax;
		end else if (v < acc_t'(WordMin)) begin
			r = WordMin;
		end else begin
			r = v[WordW-1:0];
		end
		return r;
	endfunction

	// Q14.4 output, clamped to 18 bits
	function automatic out_t sat_out(input word_t y);
		logic signed [WordW-OutShift-1:0] r;
		out_t o;
		r = y[WordW-1:OutShift];
		if (r > $signed({{(WordW-OutShift-OutW){1'b0}}, OutMax})) begin
			o = OutMax;
		end else if (r < $signed({{(WordW-OutShift-OutW){1'b1}}, OutMin})) begin
			o = OutMin;
		end else begin
			o = r[OutW-1:0];
		end
		return o;
	endfunction

endpackage

`default_nettype wire

### rtl/butterworth_bandpass_biquad_cascade.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | signals                                | payload
// ----------+----------------------------------------+------------------------------
// input     | sample_valid, sample_ready             | sample   (12 b, unsigned)
// output    | filtered_valid, filtered_ready         | filtered (18 b, signed Q14.4)
//
// filtered_valid rises once all four sections have run for an accepted request. Each
// steps through Read, Load, X1, X2, Xs, Y0, Y1, Y2 and Ys, the shared multiply pair
// issuing one coefficient term a cycle and the delay memory read registered. No new
// request is taken until the last section is done. Reset clears the sections' delay words
// through per-entry valid bits at once; no clearing pass. A new request is taken while
// the previous result waits; the last section holds until the output register is free.
module butterworth_bandpass_biquad_cascade
	import bbbc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sample_valid,
	output logic                    sample_ready,
	input  wire logic [SampleW-1:0] sample,
	output logic                    filtered_valid,
	input  wire logic               filtered_ready,
	output logic signed [OutW-1:0]  filtered
);

	typedef enum logic [9:0] {
		StIdle = 10'b00_0000_0001,
		StRead = 10'b00_0000_0010,
		StLoad = 10'b00_0000_0100,
		StX1   = 10'b00_0000_1000,
		StX2   = 10'b00_0001_0000,
		StXs   = 10'b00_0010_0000,
		StY0   = 10'b00_0100_0000,
		StY1   = 10'b00_1000_0000,
		StY2   = 10'b01_0000_0000,
		StYs   = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	logic [SecW-1:0] sec_q;

	// delay memory: {z1, z2} per section
	logic [2*WordW-1:0] mem_q [NSec];
	logic [2*WordW-1:0] rdata_q;
	logic [NSec-1:0]    valid_q;
	logic               rvalid_q;
	logic               mem_we;

	word_t u_q, z1_q, z2_q, x_q;
	acc_t  acc_q;
	prod_t prod_hi_s1, prod_lo_s1;
	out_t  filtered_q;
	logic  filtered_valid_q;

	logic      mul_go;
	coef_sel_t mul_sel;
	word_t     mul_z;
	oper_t     oper_hi, oper_lo;
	coef_t     mul_coef;
	full_t     full_prod;
	acc_t      term;
	word_t     x_new, y_new;
	logic      last_sec, out_free;

	assign sample_ready   = (state_q == StIdle);
	assign filtered_valid = filtered_valid_q;
	assign filtered       = filtered_q;

	assign last_sec = (sec_q == SecW'(NSec - 1));
	assign out_free = !filtered_valid_q || filtered_ready;

	// pick the term issued this cycle
	always_comb begin
		mul_go  = 1'b1;
		mul_sel = CoefA1;
		mul_z   = z1_q;
		case (state_q)
			StX1: begin
				mul_sel = CoefA1;
				mul_z   = z1_q;
			end
			StX2: begin
				mul_sel = CoefA2;
				mul_z   = z2_q;
			end
			StY0: begin
				mul_sel = CoefB0;
				mul_z   = x_q;
			end
			StY1: begin
				mul_sel = CoefB1;
				mul_z   = z1_q;
			end
			StY2: begin
				mul_sel = CoefB2;
				mul_z   = z2_q;
			end
			default: mul_go = 1'b0;
		endcase
	end

	assign mul_coef = coef_lookup(sec_q, mul_sel);
	assign oper_hi  = oper_t'($signed(mul_z[WordW-1:HalfW]));
	assign oper_lo  = $signed({1'b0, mul_z[HalfW-1:0]});

	// split the 40-bit word into a signed high half and an unsigned low half
	always_ff @(posedge clk) begin
		if (mul_go) begin
			prod_hi_s1 <= mul_coef * oper_hi;
			prod_lo_s1 <= mul_coef * oper_lo;
		end
	end

	// exact product, then floor by the fraction shift
	assign full_prod = (full_t'(prod_hi_s1) <<< HalfW) + full_t'(prod_lo_s1);
	assign term      = acc_t'(full_prod >>> FracW);
	assign x_new     = sat_word(acc_q - term);
	assign y_new     = sat_word(acc_q + term);

	assign mem_we = (state_q == StXs);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[sec_q] <= {x_new, z1_q};
		end
		rdata_q <= mem_q[sec_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= valid_q[sec_q];
			if (mem_we) begin
				valid_q[sec_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			StIdle: begin
				if (sample_valid) begin
					u_q <= word_t'({sample, {FracW{1'b0}}});
				end
			end
			StLoad: begin
				// entries never written read as zero
				z1_q  <= rvalid_q ? rdata_q[2*WordW-1:WordW] : '0;
				z2_q  <= rvalid_q ? rdata_q[WordW-1:0] : '0;
				acc_q <= acc_t'(u_q);
			end
			StX2: acc_q <= acc_q - term;
			StXs: begin
				x_q   <= x_new;
				acc_q <= '0;
			end
			StY1, StY2: acc_q <= acc_q + term;
			StYs: begin
				u_q <= y_new;
				if (last_sec && out_free) begin
					filtered_q <= sat_out(y_new);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= StIdle;
			sec_q            <= '0;
			filtered_valid_q <= 1'b0;
		end else begin
			if (filtered_valid_q && filtered_ready && !(state_q == StYs && last_sec)) begin
				filtered_valid_q <= 1'b0;
			end
			case (state_q)
				StIdle: begin
					if (sample_valid) begin
						sec_q   <= '0;
						state_q <= StRead;
					end
				end
				StRead: state_q <= StLoad;
				StLoad: state_q <= StX1;
				StX1:   state_q <= StX2;
				StX2:   state_q <= StXs;
				StXs:   state_q <= StY0;
				StY0:   state_q <= StY1;
				StY1:   state_q <= StY2;
				StY2:   state_q <= StYs;
				StYs: begin
					if (!last_sec) begin
						sec_q   <= sec_q + 1'b1;
						state_q <= StRead;
					end else if (out_free) begin
						// hold here until the output register frees up
						sec_q            <= '0;
						filtered_valid_q <= 1'b1;
						state_q          <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

endmodule

`default_nettype wire

### tb/butterworth_bandpass_biquad_cascade_test.sv
`timescale 1ns / 1ps

module butterworth_bandpass_biquad_cascade_test;
	import bbbc_pkg::*;

	localparam int ItemCount  = 500;
	localparam int TailItems  = 60;
	localparam int CycleLimit = 400000;
	localparam int SettleCycles = 80;

	typedef logic signed [79:0] wide_t;

	typedef struct {
		logic [SampleW-1:0] value;
		bit                 drain_first;
	} sample_req_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               sample_valid = 1'b0;
	logic               sample_ready;
	logic [SampleW-1:0] sample = '0;
	logic               filtered_valid;
	logic               filtered_ready = 1'b0;
	logic signed [OutW-1:0] filtered;

	sample_req_t sample_backlog [$];
	out_t        filtered_due [$];

	// Q3.24 taps per section, indexed by coefficient select
	longint section_coef [NSec][5] = '{
		'{ 11858519,  2620774,  4708512,   9417023,  4708512 },
		'{ 15943090,  9071967, 16777216,  33554432, 16777216 },
		'{-32776034, 16009392, 16777216, -33554432, 16777216 },
		'{-33227034, 16460352, 16777216, -33554432, 16777216 }
	};
	word_t delay_z1 [NSec];
	word_t delay_z2 [NSec];

	int accepted_count = 0;
	int total_items = 1 << 30;
	int mismatch_count = 0;
	int send_gap = 0;
	int take_gap = 0;
	int cycle_count = 0;
	bit quiet_tail;

	butterworth_bandpass_biquad_cascade i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_ready   (sample_ready),
		.sample         (sample),
		.filtered_valid (filtered_valid),
		.filtered_ready (filtered_ready),
		.filtered       (filtered)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor(c * z / 2^24), exact in the wide type
	function automatic wide_t scaled_product(input longint c, input word_t z);
		wide_t p;
		p = wide_t'(c) * wide_t'(z);
		return p >>> FracW;
	endfunction

	function automatic word_t clip_word(input wide_t v);
		word_t r;
		if (v > wide_t'(WordMax)) begin
			r = WordMax;
		end else if (v < wide_t'(WordMin)) begin
			r = WordMin;
		end else begin
			r = v[WordW-1:0];
		end
		return r;
	endfunction

	// run one reading through the four sections and advance the delay words
	function automatic out_t bandpass_predict(input logic [SampleW-1:0] s);
		wide_t u;
		wide_t r;
		word_t x;
		word_t y;
		out_t  o;
		u = wide_t'({1'b0, s}) <<< FracW;
		for (int k = 0; k < NSec; k++) begin
			x = clip_word(u - scaled_product(section_coef[k][CoefA1], delay_z1[k])
				- scaled_product(section_coef[k][CoefA2], delay_z2[k]));
			y = clip_word(scaled_product(section_coef[k][CoefB0], x)
				+ scaled_product(section_coef[k][CoefB1], delay_z1[k])
				+ scaled_product(section_coef[k][CoefB2], delay_z2[k]));
			delay_z2[k] = delay_z1[k];
			delay_z1[k] = x;
			u = wide_t'(y);
		end
		r = u >>> OutShift;
		if (r > wide_t'(OutMax)) begin
			o = OutMax;
		end else if (r < wide_t'(OutMin)) begin
			o = OutMin;
		end else begin
			o = r[OutW-1:0];
		end
		return o;
	endfunction

	task automatic queue_sample(input int v, input bit drain_first);
		sample_req_t req;
		req.value = v[SampleW-1:0];
		req.drain_first = drain_first;
		sample_backlog.push_back(req);
	endtask

	assign quiet_tail = accepted_count >= total_items - TailItems;

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			if (sample_valid && sample_ready) begin
				filtered_due.push_back(bandpass_predict(sample));
				accepted_count <= accepted_count + 1;
			end
			if (!sample_valid || sample_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					sample_valid <= 1'b0;
				end else if (sample_backlog.size() == 0) begin
					sample_valid <= 1'b0;
				end else if (sample_backlog[0].drain_first && filtered_due.size() != 0) begin
					// hold until the pipeline has emptied
					sample_valid <= 1'b0;
				end else if (!quiet_tail && cycle_count[7] && $urandom_range(0, 5) == 0) begin
					send_gap <= $urandom_range(0, 4);
					sample_valid <= 1'b0;
				end else begin
					sample <= sample_backlog[0].value;
					sample_valid <= 1'b1;
					void'(sample_backlog.pop_front());
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		out_t want;
		if (!arst_n) begin
			filtered_ready <= 1'b0;
		end else begin
			if (filtered_valid && filtered_ready) begin
				if (filtered_due.size() == 0) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < 10)
						$display("unexpected result: filtered=%0d", filtered);
				end else begin
					want = filtered_due.pop_front();
					if (filtered !== want) begin
						mismatch_count <= mismatch_count + 1;
						if (mismatch_count < 10)
							$display("mismatch: filtered expected %0d got %0d", want, filtered);
					end
				end
			end
			if (take_gap > 0) begin
				take_gap <= take_gap - 1;
				filtered_ready <= 1'b0;
			end else if (!quiet_tail && !cycle_count[6] && $urandom_range(0, 4) == 0) begin
				take_gap <= $urandom_range(0, 4);
				filtered_ready <= 1'b0;
			end else begin
				filtered_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int kind;
		int len;
		int level;
		int level2;
		int half;
		int step;
		int v;
		bit drained_mid;

		for (int k = 0; k < NSec; k++) begin
			delay_z1[k] = '0;
			delay_z2[k] = '0;
		end
		drained_mid = 1'b0;

		// extremes, a full-scale step long enough to clip the inner sections, then a drop
		queue_sample(0, 1'b0);
		queue_sample(0, 1'b0);
		for (int n = 0; n < 12; n++)
			queue_sample(4095, 1'b0);
		for (int n = 0; n < 4; n++)
			queue_sample(0, 1'b0);
		for (int n = 0; n < 6; n++)
			queue_sample((n % 2) ? 4095 : 0, 1'b0);
		queue_sample(2048, 1'b0);

		// random segments of steady levels, square waves, noise and ramps
		queue_sample($urandom_range(0, 4095), 1'b1);
		while (sample_backlog.size() < ItemCount) begin
			kind = $urandom_range(0, 3);
			len = $urandom_range(8, 40);
			level = $urandom_range(0, 4095);
			level2 = $urandom_range(0, 4095);
			half = $urandom_range(1, 10);
			step = $urandom_range(1, 200);
			if (kind == 0 && $urandom_range(0, 2) == 0)
				level = $urandom_range(0, 1) ? 4095 : 0;
			for (int n = 0; n < len; n++) begin
				case (kind)
					0: v = level;
					1: v = ((n / half) % 2) ? level : level2;
					2: v = $urandom_range(0, 4095);
					default: v = (level + n * step) % 4096;
				endcase
				queue_sample(v, !drained_mid && sample_backlog.size() >= ItemCount / 2);
				if (sample_backlog.size() > ItemCount / 2)
					drained_mid = 1'b1;
			end
		end
		total_items = sample_backlog.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (sample_backlog.size() != 0 || sample_valid || filtered_due.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### butterworth_bandpass_biquad_cascade.f
rtl/bbbc_pkg.sv
rtl/butterworth_bandpass_biquad_cascade.sv
tb/butterworth_bandpass_biquad_cascade_test.sv
